[rtl/core/rste_pkg.sv]
// ----------------------------------------------------------------------------
// Range sum tree engine package
// Shared widths, operation codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package rste_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;
    localparam int CFG_W  = 11;
    // Wide enough for an element count of up to 65536.
    localparam int CNT_W  = 17;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_ADD   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic run_step;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic go_run;
        logic clear_last;
        logic run_last;
        logic pend;
    } sts_t;

endpackage

[rtl/core/rste_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rste_dp.sv]
// ----------------------------------------------------------------------------
// Range sum tree engine datapath
// Element store, range decode, leaf sweep pointer, accumulator and result.
// ----------------------------------------------------------------------------
module rste_dp #(
    parameter int LEAVES = 1024,
    parameter int AW     = (LEAVES > 1) ? $clog2(LEAVES) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [rste_pkg::CFG_W-1:0] element_count,
    input  logic [1:0]                 s_op,
    input  logic [rste_pkg::IDX_W-1:0] s_first_index,
    input  logic [rste_pkg::IDX_W-1:0] s_last_index,
    input  logic signed [31:0]         s_amount,
    input  rste_pkg::cmd_t             cmd,
    output rste_pkg::sts_t             sts,
    output logic signed [31:0]         m_range_sum
);

    localparam int CW = rste_pkg::CNT_W;

    logic [CW-1:0] n, a_ext, b_ext, b_clip;
    logic          a_ok, live;
    rste_pkg::op_t op_in;

    logic [AW-1:0]     ptr_reg, last_reg, pend_addr_reg;
    logic              pend_reg;
    logic [31:0]       amt_reg, acc_reg, rdata;
    logic signed [31:0] sum_reg;
    rste_pkg::op_t     op_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    always_comb begin
        op_in  = rste_pkg::op_t'(s_op);
        n      = ({{(CW - rste_pkg::CFG_W){1'b0}}, element_count} > CW'(LEAVES))
                 ? CW'(LEAVES)
                 : {{(CW - rste_pkg::CFG_W){1'b0}}, element_count};
        a_ext  = {{(CW - rste_pkg::IDX_W){1'b0}}, s_first_index};
        b_ext  = {{(CW - rste_pkg::IDX_W){1'b0}}, s_last_index};
        b_clip = (n != '0 && b_ext > n - CW'(1)) ? n - CW'(1) : b_ext;
        a_ok   = (n != '0) && (a_ext < n);
        live   = a_ok && (a_ext <= b_clip);
    end

    // Write port: clearing pass, element load, or read-modify-write of a range add.
    always_comb begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = '0;
        if (cmd.clear_step) begin
            we = 1'b1;
        end else if (cmd.accept && op_in == rste_pkg::OP_LOAD && a_ok) begin
            we    = 1'b1;
            waddr = a_ext[AW-1:0];
            wdata = s_amount;
        end else if (pend_reg && op_reg == rste_pkg::OP_ADD) begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = rdata + amt_reg;
        end
    end

    rste_ram #(
        .WIDTH (32),
        .DEPTH (LEAVES),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.run_step;
            if (cmd.accept) begin
                ptr_reg <= a_ext[AW-1:0];
            end else if (cmd.clear_step || cmd.run_step) begin
                ptr_reg <= ptr_reg + AW'(1);
            end
        end
        if (cmd.accept) begin
            last_reg <= b_clip[AW-1:0];
            amt_reg  <= s_amount;
            op_reg   <= op_in;
            acc_reg  <= '0;
        end else if (pend_reg && op_reg == rste_pkg::OP_QUERY) begin
            acc_reg <= acc_reg + rdata;
        end
        if (cmd.run_step) begin
            pend_addr_reg <= ptr_reg;
        end
        if (cmd.publish) begin
            sum_reg <= acc_reg;
        end
    end

    always_comb begin
        sts.go_run     = live && (op_in == rste_pkg::OP_QUERY || op_in == rste_pkg::OP_ADD);
        sts.clear_last = (ptr_reg == AW'(LEAVES - 1));
        sts.run_last   = (ptr_reg == last_reg);
        sts.pend       = pend_reg;
    end

    assign m_range_sum = sum_reg;

endmodule

[rtl/core/rste_ctrl.sv]
// ----------------------------------------------------------------------------
// Range sum tree engine controller
// Sequences the clearing pass, the leaf sweep of each request and the result.
// ----------------------------------------------------------------------------
module rste_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  rste_pkg::sts_t sts,
    output rste_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd.accept     = s_valid && s_ready;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.run_step   = (state_reg == ST_RUN);
        cmd.publish    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

        state_next   = state_reg;
        m_valid_next = cmd.publish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cmd.accept) state_next = sts.go_run ? ST_RUN : ST_DONE;
            end
            ST_RUN: begin
                if (sts.run_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (cmd.publish) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_drain_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAIN |-> sts.pend)
        else $error("drain without a read in flight");

    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid_reg)
        else $error("published result not presented");

    a_short_request: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && !sts.go_run |=> state_reg == ST_DONE)
        else $error("request without sweep did not finish at once");

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("request taken during clearing pass");

endmodule

[rtl/core/range_sum_tree_engine.sv]
// ----------------------------------------------------------------------------
// Range sum tree engine
// Element store with loads, range sum queries and range adds over 32-bit
// wrapping values.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every entry of its element
// memory and takes no request until it ends; element_count writes are taken
// throughout. A load, an unused op or an empty or clipped-away range goes from
// idle straight to the done state, where its result is registered and shown
// once the output register is free; the next request can be taken after that.
// A range query or range add sweeps the clipped range one element per cycle
// through the single read port of the element memory, then passes a drain
// state for the last read before its result is registered in the done state.
// One request is handled at a time, and the next one is taken while the
// previous result still waits in the output register; its own result then
// waits, holding the block, until that register is free. Node sums of a tree
// equal wrapped sums of their leaves, so only the leaves are stored.
// ----------------------------------------------------------------------------
module range_sum_tree_engine #(
    parameter int LEAVES = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rste_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic [rste_pkg::IDX_W-1:0] s_first_index,
    input  logic [rste_pkg::IDX_W-1:0] s_last_index,
    input  logic signed [31:0]         s_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_range_sum
);

    localparam int AW = (LEAVES > 1) ? $clog2(LEAVES) : 1;

    // The element count register; the datapath limits it to LEAVES.
    logic [rste_pkg::CFG_W-1:0] count_reg;
    rste_pkg::cmd_t             cmd;
    rste_pkg::sts_t             sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= rste_pkg::CFG_W'(1024);
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    // The controller owns the handshakes and the sequencing of each request.
    rste_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the elements, decodes the range and accumulates.
    rste_dp #(
        .LEAVES (LEAVES),
        .AW     (AW)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .element_count (count_reg),
        .s_op          (s_op),
        .s_first_index (s_first_index),
        .s_last_index  (s_last_index),
        .s_amount      (s_amount),
        .cmd           (cmd),
        .sts           (sts),
        .m_range_sum   (m_range_sum)
    );

endmodule

[tb/range_sum_tree_engine_tb.sv]
// ----------------------------------------------------------------------------
// Range sum tree engine testbench
// Drives loads, range queries and range adds through the request channel and
// checks every result against a behavioral model of the element array or a
// typed expected sum. The run includes a directed table, then random traffic
// over several element counts, random gaps on both channels in all but one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module range_sum_tree_engine_tb;

    localparam int LEAVES = 1024;

    typedef struct {
        rste_pkg::op_t                op;
        logic [rste_pkg::IDX_W-1:0]   first;
        logic [rste_pkg::IDX_W-1:0]   last;
        logic signed [31:0]           amount;
        bit                           typed;
        logic signed [31:0]           sum;
    } row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_we;
    logic [rste_pkg::CFG_W-1:0] cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [1:0]                 s_op;
    logic [rste_pkg::IDX_W-1:0] s_first_index;
    logic [rste_pkg::IDX_W-1:0] s_last_index;
    logic signed [31:0]         s_amount;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [31:0]         m_range_sum;

    // Model state: the leaves alone, since every node sum is the wrapped sum
    // of the leaves below it.
    logic [31:0]                leaf_val [LEAVES];
    logic [rste_pkg::CFG_W-1:0] elem_count;
    logic signed [31:0]         sum_queue [$];
    row_t                       directed [$];
    int                         req_taken;
    int                         errors;
    bit                         no_gaps;

    range_sum_tree_engine #(.LEAVES(LEAVES)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_first_index (s_first_index),
        .s_last_index  (s_last_index),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_sum   (m_range_sum)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Applies one request to the model and returns the sum it should report.
    // The count is clipped to LEAVES, and the range end is clipped to the
    // count; a reversed or out-of-count range leaves everything untouched.
    function automatic logic signed [31:0] apply_request(rste_pkg::op_t op, int first,
                                                         int last, logic [31:0] amount);
        int          n;
        int          hi;
        logic [31:0] acc;
        n   = (elem_count > LEAVES) ? LEAVES : elem_count;
        hi  = (last > n - 1) ? n - 1 : last;
        acc = '0;
        case (op)
            rste_pkg::OP_LOAD: begin
                if (first < n) leaf_val[first] = amount;
            end
            rste_pkg::OP_QUERY: begin
                for (int i = first; i <= hi; i++) acc += leaf_val[i];
            end
            rste_pkg::OP_ADD: begin
                for (int i = first; i <= hi; i++) leaf_val[i] += amount;
            end
            default: ;
        endcase
        return acc;
    endfunction

    // Counts accepted requests, sampled at the rising edge.
    always @(posedge aclk) begin
        if (s_valid && s_ready) req_taken++;
    end

    // Checks each accepted result against the oldest expected sum.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (sum_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, m_range_sum);
                errors++;
            end else begin
                if (m_range_sum !== sum_queue[0]) begin
                    $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                             $time, sum_queue[0], m_range_sum);
                    errors++;
                end
                void'(sum_queue.pop_front());
            end
        end
    end

    // The result side stalls in about a quarter of the cycles, except during
    // the quiet stretch.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = no_gaps || ($urandom_range(99) >= 25);
        end
    end

    // Presents one request and holds it until it is taken. The model is
    // updated at presentation, which keeps it in request order.
    task automatic send_request(rste_pkg::op_t op, int first, int last, logic [31:0] amount,
                                bit typed, logic signed [31:0] typed_sum);
        int                 seen;
        logic signed [31:0] predicted;
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 25) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        predicted     = apply_request(op, first, last, amount);
        sum_queue.push_back(typed ? typed_sum : predicted);
        seen          = req_taken;
        s_valid       = 1'b1;
        s_op          = op;
        s_first_index = first[rste_pkg::IDX_W-1:0];
        s_last_index  = last[rste_pkg::IDX_W-1:0];
        s_amount      = amount;
        while (req_taken == seen) @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Waits for every result and a pause after it, then writes the element count
    // while the block is idle.
    task automatic set_count(logic [rste_pkg::CFG_W-1:0] value);
        while (sum_queue.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we     = 1'b1;
        cfg_wdata  = value;
        elem_count = value;
        @(negedge aclk);
        cfg_we     = 1'b0;
    endtask

    task automatic add_row(rste_pkg::op_t op, int first, int last, logic [31:0] amount,
                           bit typed, logic signed [31:0] sum);
        row_t r;
        r.op = op; r.first = first[rste_pkg::IDX_W-1:0]; r.last = last[rste_pkg::IDX_W-1:0];
        r.amount = amount; r.typed = typed; r.sum = sum;
        directed.push_back(r);
    endtask

    // One random request shaped around the current count: mostly short
    // ranges inside it, a few spanning the whole array, some past the end
    // or reversed, and the odd unused op.
    task automatic random_request();
        int            pick;
        int            n;
        int            first;
        int            last;
        logic [31:0]   amount;
        rste_pkg::op_t op;
        n    = (elem_count > LEAVES) ? LEAVES : elem_count;
        pick = $urandom_range(99);
        op   = (pick < 35) ? rste_pkg::OP_LOAD
             : (pick < 70) ? rste_pkg::OP_QUERY
             : (pick < 95) ? rste_pkg::OP_ADD
                           : rste_pkg::OP_NONE;
        pick = $urandom_range(99);
        if (pick < 3) begin
            first = $urandom_range(3);
            last  = LEAVES - 1 - $urandom_range(3);
        end else if (pick < 15) begin
            first = $urandom_range(LEAVES - 1);
            last  = $urandom_range(LEAVES - 1);
            if (last > first + 40) last = first + $urandom_range(40);
            if ($urandom_range(1)) last = first - $urandom_range(first < 5 ? first : 5);
        end else begin
            first = (n == 0) ? $urandom_range(LEAVES - 1) : $urandom_range(n - 1);
            last  = first + $urandom_range(15);
            if (last > LEAVES - 1) last = LEAVES - 1;
        end
        pick = $urandom_range(9);
        amount = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7fff_ffff
               : (pick < 5) ? $urandom_range(15) - 8 : $urandom;
        send_request(op, first, last, amount, 1'b0, '0);
    endtask

    initial begin
        logic [rste_pkg::CFG_W-1:0] counts [8];
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_op          = rste_pkg::OP_LOAD;
        s_first_index = '0;
        s_last_index  = '0;
        s_amount      = '0;
        elem_count    = 11'd1024;
        req_taken     = 0;
        errors        = 0;
        no_gaps       = 1'b0;
        foreach (leaf_val[i]) leaf_val[i] = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. The cleared array sums to zero, loads, adds and the
        // unused op answer zero, and so does a reversed range.
        add_row(rste_pkg::OP_QUERY, 0, 1023, 0, 1, 0);
        add_row(rste_pkg::OP_LOAD, 0, 0, 32'h7fff_ffff, 1, 0);
        add_row(rste_pkg::OP_LOAD, 1023, 0, 32'h8000_0000, 1, 0);
        add_row(rste_pkg::OP_QUERY, 0, 1023, 0, 1, -1);
        add_row(rste_pkg::OP_QUERY, 1023, 1023, 0, 1, 32'sh8000_0000);
        add_row(rste_pkg::OP_ADD, 0, 1023, 1, 1, 0);
        add_row(rste_pkg::OP_QUERY, 0, 1023, 0, 0, 0);
        add_row(rste_pkg::OP_QUERY, 5, 3, 0, 1, 0);
        add_row(rste_pkg::OP_ADD, 9, 2, 32'h1234, 1, 0);
        add_row(rste_pkg::OP_NONE, 0, 1023, 32'hffff_ffff, 1, 0);
        add_row(rste_pkg::OP_QUERY, 0, 15, 0, 0, 0);
        add_row(rste_pkg::OP_ADD, 100, 199, 32'h8000_0000, 1, 0);
        add_row(rste_pkg::OP_QUERY, 50, 250, 0, 0, 0);
        add_row(rste_pkg::OP_LOAD, 512, 0, 32'hffff_ffff, 1, 0);
        add_row(rste_pkg::OP_QUERY, 511, 513, 0, 0, 0);
        add_row(rste_pkg::OP_QUERY, 1023, 0, 0, 1, 0);
        add_row(rste_pkg::OP_QUERY, 682, 341, 0, 1, 0);
        add_row(rste_pkg::OP_QUERY, 341, 682, 0, 0, 0);
        foreach (directed[i])
            send_request(directed[i].op, directed[i].first, directed[i].last,
                         directed[i].amount, directed[i].typed, directed[i].sum);

        // Random phases over several counts, extremes included. A zero count
        // disables every element, and counts above LEAVES clip to it.
        counts = '{11'd1024, 11'd1, 11'd0, 11'd2047, 11'd17, 11'd1000, 11'd600, 11'd1024};
        counts[6] = rste_pkg::CFG_W'($urandom_range(2047));
        foreach (counts[p]) begin
            set_count(counts[p]);
            for (int k = 0; k < 120; k++) begin
                no_gaps = (p == 3);
                random_request();
            end
            no_gaps = 1'b0;
        end

        while (sum_queue.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("range_sum_tree_engine_tb: PASS");
        end else begin
            $display("range_sum_tree_engine_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("range_sum_tree_engine_tb: FAIL");
        $finish;
    end

endmodule

[range_sum_tree_engine.f]
rtl/core/rste_pkg.sv
rtl/core/rste_ram.sv
rtl/core/rste_dp.sv
rtl/core/rste_ctrl.sv
rtl/core/range_sum_tree_engine.sv
tb/range_sum_tree_engine_tb.sv
